// ===== hw/rtl/i2cbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and codes for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

   localparam int MAX_BYTES = 16;
   localparam int LEN_W     = 5;
   localparam int IDX_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // request actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_LOAD  = 2'd2;

   // line actions
   localparam logic [1:0] DRV_NONE = 2'd0;
   localparam logic [1:0] DRV_HIGH = 2'd1;
   localparam logic [1:0] DRV_LOW  = 2'd2;

   // transaction status
   localparam logic [1:0] RC_UNKNOWN = 2'd0;
   localparam logic [1:0] RC_BUSY    = 2'd1;
   localparam logic [1:0] RC_OK      = 2'd2;
   localparam logic [1:0] RC_FAIL    = 2'd3;

   // start answers
   localparam logic [1:0] SE_OK        = 2'd0;
   localparam logic [1:0] SE_NOT_READY = 2'd1;
   localparam logic [1:0] SE_BAD_LEN   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_ENABLED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS    = 2'd2;

   typedef struct packed {
      logic [1:0]       action;
      logic             sda_in;
      logic             scl_in;
      logic [LEN_W-1:0] length;
      logic             read_mode;
      logic             restart;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0]       scl_drive;
      logic [1:0]       sda_drive;
      logic [1:0]       status;
      logic             busy_res;
      logic             rx_valid;
      logic [7:0]       rx_byte;
      logic [IDX_W-1:0] rx_index;
      logic [1:0]       start_error;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// Single-port I2C master stepped by quarter-bit ticks.
// ----------------------------------------------------------------------------
// Each item (a tick with sampled SDA/SCL, a start request or a write byte load)
// is handled at the edge that accepts it: the bus and transfer state update at
// that edge and its answer lands in the output register at the same edge, so
// one item per cycle is sustained while rsp_stall is low. A result
// waiting in the output register does not block the next item unless it is
// stalled. Write bytes are held in a 16-entry register file read at the
// current byte position. Configuration writes are always ready and take
// effect at the edge of the write.
module i2c_master_bit_sequencer_core
   import i2cbs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      BP_OFF      = 5'd0,
      BP_IDLE     = 5'd1,
      BP_PAUSE    = 5'd2,
      BP_RECLOCK0 = 5'd3,
      BP_RECLOCK1 = 5'd4,
      BP_RACK0    = 5'd5,
      BP_RACK1    = 5'd6,
      BP_RACK2    = 5'd7,
      BP_WACK0    = 5'd8,
      BP_WACK1    = 5'd9,
      BP_WACK2    = 5'd10,
      BP_START0   = 5'd11,
      BP_START1   = 5'd12,
      BP_SCL_LOW  = 5'd13,
      BP_SAMPLE0  = 5'd14,
      BP_SAMPLE1  = 5'd15,
      BP_SAMPLE2  = 5'd16,
      BP_STOP0    = 5'd17,
      BP_STOP1    = 5'd18
   } bus_phase_type;

   typedef enum logic [2:0] {
      TP_NONE     = 3'd0,
      TP_WAITING  = 3'd1,
      TP_START    = 3'd2,
      TP_BYTE     = 3'd3,
      TP_GIVE_ACK = 3'd4,
      TP_TAKE_ACK = 3'd5,
      TP_STOP     = 3'd6
   } xfer_phase_type;

   bus_phase_type    bus_phase_ff, bus_phase_in;
   bus_phase_type    after_pause_ff, after_pause_in;
   xfer_phase_type   xfer_phase_ff, xfer_phase_in;
   logic             mode_is_read_ff, mode_is_read_in;
   logic             restart_pending_ff, restart_pending_in;
   logic [LEN_W-1:0] xfer_len_ff, xfer_len_in;
   logic [LEN_W-1:0] bytes_done_ff, bytes_done_in;
   logic [7:0]       shift_byte_ff, shift_byte_in;
   logic [3:0]       bit_pos_ff, bit_pos_in;
   logic [1:0]       result_code_ff, result_code_in;
   logic [7:0]       pause_left_ff, pause_left_in;
   logic [6:0]       dev_addr_ff, dev_addr_in;
   logic [7:0]       pause_ticks_ff, pause_ticks_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [7:0]       wbuf_ff [MAX_BYTES];
   logic             wbuf_we;

   logic             req_accept;
   logic             csr_write;
   logic             busy_now;
   logic [1:0]       scl_d;
   logic [1:0]       sda_d;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign busy_now   = (bus_phase_ff > BP_IDLE) || (result_code_ff == RC_BUSY);
   assign wbuf_we    = req_accept && (req_data.action == ACT_LOAD);

   always_comb begin
      bus_phase_in       = bus_phase_ff;
      after_pause_in     = after_pause_ff;
      xfer_phase_in      = xfer_phase_ff;
      mode_is_read_in    = mode_is_read_ff;
      restart_pending_in = restart_pending_ff;
      xfer_len_in        = xfer_len_ff;
      bytes_done_in      = bytes_done_ff;
      shift_byte_in      = shift_byte_ff;
      bit_pos_in         = bit_pos_ff;
      result_code_in     = result_code_ff;
      pause_left_in      = pause_left_ff;
      dev_addr_in        = dev_addr_ff;
      pause_ticks_in     = pause_ticks_ff;
      rsp_data_in        = '0;
      scl_d              = DRV_NONE;
      sda_d              = DRV_NONE;

      if (req_accept) begin
         case (req_data.action)
            ACT_TICK: begin
               case (bus_phase_ff)
                  BP_RECLOCK0: begin
                     scl_d        = DRV_LOW;
                     bus_phase_in = BP_RECLOCK1;
                  end
                  BP_RECLOCK1: begin
                     scl_d        = DRV_HIGH;
                     bus_phase_in = BP_START0;
                  end
                  BP_RACK0: begin
                     scl_d        = DRV_HIGH;
                     bus_phase_in = BP_RACK1;
                  end
                  BP_RACK1: begin
                     // slave may stretch the clock here
                     if (req_data.scl_in) begin
                        bus_phase_in = BP_RACK2;
                     end
                  end
                  BP_RACK2: begin
                     if (req_data.sda_in) begin
                        result_code_in = RC_FAIL;
                        bus_phase_in   = BP_STOP0;
                        xfer_phase_in  = TP_STOP;
                     end else begin
                        if (bytes_done_ff <= xfer_len_ff) begin
                           xfer_phase_in = TP_BYTE;
                        end else begin
                           result_code_in = RC_OK;
                           xfer_phase_in  = TP_STOP;
                        end
                        scl_d        = DRV_LOW;
                        bus_phase_in = BP_SCL_LOW;
                     end
                  end
                  BP_WACK0: begin
                     scl_d        = DRV_HIGH;
                     bus_phase_in = BP_WACK1;
                  end
                  BP_WACK1: begin
                     scl_d        = DRV_LOW;
                     bus_phase_in = BP_WACK2;
                  end
                  BP_WACK2: begin
                     sda_d         = DRV_HIGH;
                     bus_phase_in  = BP_SCL_LOW;
                     xfer_phase_in = TP_BYTE;
                  end
                  BP_IDLE: begin
                     if (xfer_phase_ff == TP_WAITING) begin
                        sda_d         = DRV_HIGH;
                        scl_d         = DRV_HIGH;
                        xfer_phase_in = TP_START;
                        bus_phase_in  = restart_pending_ff ? BP_RECLOCK0 : BP_START0;
                     end
                  end
                  BP_PAUSE: begin
                     pause_left_in = pause_left_ff - 8'd1;
                     if (pause_left_in == 8'd0) begin
                        bus_phase_in = after_pause_ff;
                     end
                  end
                  BP_START0: begin
                     if (req_data.sda_in) begin
                        sda_d          = DRV_LOW;
                        bus_phase_in   = BP_PAUSE;
                        pause_left_in  = pause_ticks_ff;
                        after_pause_in = BP_START1;
                     end else begin
                        // sda held low: reclock and try again
                        bus_phase_in = BP_RECLOCK0;
                     end
                  end
                  BP_START1: begin
                     scl_d          = DRV_LOW;
                     shift_byte_in  = {dev_addr_ff, mode_is_read_ff};
                     bit_pos_in     = 4'd7;
                     bytes_done_in  = '0;
                     bus_phase_in   = BP_PAUSE;
                     pause_left_in  = pause_ticks_ff;
                     after_pause_in = BP_SCL_LOW;
                     xfer_phase_in  = TP_BYTE;
                  end
                  BP_SCL_LOW: begin
                     case (xfer_phase_ff)
                        TP_BYTE: begin
                           if (!mode_is_read_ff || bytes_done_ff == '0) begin
                              if (!bit_pos_ff[3] && shift_byte_ff[bit_pos_ff[2:0]]) begin
                                 sda_d = DRV_HIGH;
                              end else begin
                                 sda_d = DRV_LOW;
                              end
                              bit_pos_in = bit_pos_ff - 4'd1;
                           end
                           bus_phase_in = BP_SAMPLE0;
                        end
                        TP_GIVE_ACK: begin
                           if (req_data.sda_in) begin
                              sda_d        = DRV_LOW;
                              bus_phase_in = BP_WACK0;
                           end
                        end
                        TP_TAKE_ACK: begin
                           sda_d        = DRV_HIGH;
                           scl_d        = DRV_LOW;
                           bus_phase_in = BP_RACK0;
                        end
                        TP_STOP: begin
                           sda_d          = DRV_LOW;
                           bus_phase_in   = BP_PAUSE;
                           pause_left_in  = pause_ticks_ff;
                           after_pause_in = BP_STOP0;
                        end
                        default: begin
                        end
                     endcase
                  end
                  BP_SAMPLE0: begin
                     scl_d        = DRV_HIGH;
                     bus_phase_in = BP_SAMPLE1;
                  end
                  BP_SAMPLE1: begin
                     if (mode_is_read_ff && bytes_done_ff != '0) begin
                        if (req_data.sda_in && !bit_pos_ff[3]) begin
                           shift_byte_in[bit_pos_ff[2:0]] = 1'b1;
                        end
                        bit_pos_in = bit_pos_ff - 4'd1;
                     end
                     bus_phase_in = BP_SAMPLE2;
                  end
                  BP_SAMPLE2: begin
                     scl_d = DRV_LOW;
                     // position wrapped below zero: byte finished
                     if (bit_pos_ff[3]) begin
                        if (!mode_is_read_ff) begin
                           if (bytes_done_ff < xfer_len_ff) begin
                              shift_byte_in = wbuf_ff[bytes_done_ff[IDX_W-1:0]];
                           end
                           xfer_phase_in = TP_TAKE_ACK;
                        end else if (bytes_done_ff == '0) begin
                           shift_byte_in = '0;
                           xfer_phase_in = TP_TAKE_ACK;
                        end else begin
                           rsp_data_in.rx_valid = 1'b1;
                           rsp_data_in.rx_byte  = shift_byte_ff;
                           rsp_data_in.rx_index = bytes_done_ff[IDX_W-1:0] - 4'd1;
                           shift_byte_in        = '0;
                           if (bytes_done_ff < xfer_len_ff) begin
                              xfer_phase_in = TP_GIVE_ACK;
                           end else begin
                              result_code_in = RC_OK;
                              xfer_phase_in  = TP_STOP;
                           end
                        end
                        bytes_done_in = bytes_done_ff + 5'd1;
                        bit_pos_in    = 4'd7;
                     end
                     bus_phase_in = BP_SCL_LOW;
                  end
                  BP_STOP0: begin
                     scl_d          = DRV_HIGH;
                     bus_phase_in   = BP_PAUSE;
                     pause_left_in  = pause_ticks_ff;
                     after_pause_in = BP_STOP1;
                  end
                  BP_STOP1: begin
                     sda_d          = DRV_HIGH;
                     bus_phase_in   = BP_PAUSE;
                     pause_left_in  = pause_ticks_ff;
                     after_pause_in = BP_IDLE;
                     xfer_phase_in  = TP_NONE;
                  end
                  default: begin
                  end
               endcase
            end
            ACT_START: begin
               if (busy_now) begin
                  rsp_data_in.start_error = SE_NOT_READY;
               end else if (req_data.length == '0 ||
                            req_data.length > LEN_W'(MAX_BYTES)) begin
                  rsp_data_in.start_error = SE_BAD_LEN;
               end else begin
                  xfer_phase_in      = TP_WAITING;
                  result_code_in     = RC_BUSY;
                  mode_is_read_in    = req_data.read_mode;
                  restart_pending_in = req_data.restart;
                  xfer_len_in        = req_data.length;
                  bytes_done_in      = '0;
                  shift_byte_in      = '0;
                  bit_pos_in         = '0;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_data_in.scl_drive = scl_d;
      rsp_data_in.sda_drive = sda_d;
      rsp_data_in.status    = result_code_in;
      rsp_data_in.busy_res  = (bus_phase_in > BP_IDLE) || (result_code_in == RC_BUSY);

      if (csr_write) begin
         case (csr_index)
            CSR_PORT_ENABLED: begin
               if (csr_wdata[0]) begin
                  bus_phase_in  = BP_IDLE;
                  xfer_phase_in = TP_NONE;
               end else begin
                  bus_phase_in = BP_OFF;
               end
            end
            CSR_DEVICE_ADDRESS: dev_addr_in    = csr_wdata[6:0];
            CSR_PAUSE_TICKS:    pause_ticks_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_phase_ff       <= BP_OFF;
         after_pause_ff     <= BP_IDLE;
         xfer_phase_ff      <= TP_NONE;
         mode_is_read_ff    <= 1'b0;
         restart_pending_ff <= 1'b0;
         xfer_len_ff        <= '0;
         bytes_done_ff      <= '0;
         shift_byte_ff      <= '0;
         bit_pos_ff         <= '0;
         result_code_ff     <= RC_UNKNOWN;
         pause_left_ff      <= '0;
         dev_addr_ff        <= 7'd1;
         pause_ticks_ff     <= 8'd3;
         rsp_valid_ff       <= 1'b0;
      end else begin
         bus_phase_ff       <= bus_phase_in;
         after_pause_ff     <= after_pause_in;
         xfer_phase_ff      <= xfer_phase_in;
         mode_is_read_ff    <= mode_is_read_in;
         restart_pending_ff <= restart_pending_in;
         xfer_len_ff        <= xfer_len_in;
         bytes_done_ff      <= bytes_done_in;
         shift_byte_ff      <= shift_byte_in;
         bit_pos_ff         <= bit_pos_in;
         result_code_ff     <= result_code_in;
         pause_left_ff      <= pause_left_in;
         dev_addr_ff        <= dev_addr_in;
         pause_ticks_ff     <= pause_ticks_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wbuf_we) begin
         wbuf_ff[req_data.byte_index] <= req_data.byte_value;
      end
   end

   // bit position only walks 7 down to 0 and then wraps to 15
   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      !(bit_pos_ff[3] && bit_pos_ff[2:0] != 3'b111))
      else $error("bit position outside its walk");

   // a disabled port answers ticks without touching the lines
   a_off_no_drive: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.action == ACT_TICK && bus_phase_ff == BP_OFF) |=>
      (rsp_data.scl_drive == DRV_NONE && rsp_data.sda_drive == DRV_NONE))
      else $error("line driven while port off");

   // a received byte only comes out of a tick, never with a start answer
   a_rx_not_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rx_valid) |->
      (rsp_data.start_error == SE_OK && rsp_data.status != RC_UNKNOWN))
      else $error("received byte with a start answer");

   // input only held off behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no result waiting");

endmodule
`default_nettype wire
